FILE: rtl/ddft_pkg.sv
// shared constants, types and the twiddle table for the direct dft/idft engine
// used by ddft_div, direct_dft_idft_engine_unit and its bench; depends on nothing else
package ddft_pkg;

    localparam int MAX_POINTS         = 64;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SAMPLE_BITS        = 16;

    // twiddle word is q1.15, results drop 15 fraction bits
    localparam int TW_W   = 16;
    localparam int FRAC   = 15;
    localparam int OUT_W  = 22;
    localparam int POW_W  = 43;

    localparam int PT_W    = $clog2(MAX_POINTS + 1);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int ROM_AW  = $clog2(SINE_TABLE_ENTRIES);
    localparam int R_W     = $clog2(4 * MAX_POINTS);
    localparam int PROD_W  = SAMPLE_BITS + TW_W;
    localparam int ACC_W   = PROD_W + 1 + IDX_W;
    localparam int V_W     = ACC_W + 1;
    localparam int DIV_W   = V_W - FRAC;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 1'b1;
    localparam logic [CFG_DATA_W-1:0] POINTS_RESET = CFG_DATA_W'(64);

    // 2*pi in q3.29
    localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
    localparam logic [63:0] ONE_Q30    = 64'h4000_0000;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_BIN_START,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SAT,
        ST_SQUARE,
        ST_EMIT
    } state_t;

    typedef logic signed [TW_W-1:0] sine_rom_t [SINE_TABLE_ENTRIES];

    // one table entry: quadrant fold, then an 11th order taylor series in q2.30
    function automatic logic signed [TW_W-1:0] sine_entry(input int unsigned p);
        logic [63:0] f;
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic        neg;
        neg = 1'b0;
        f = (64'(p) << 32) / 64'(SINE_TABLE_ENTRIES);
        if (f >= 64'h8000_0000)
        begin
            neg = 1'b1;
            f = f - 64'h8000_0000;
        end
        if (f > 64'h4000_0000)
            f = 64'h8000_0000 - f;
        a  = (f * TWO_PI_Q29 + 64'h4000_0000) >> 31;
        x2 = (a * a) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
        s  = (a * t) >> 30;
        s  = (s * 64'd32767 + 64'h2000_0000) >> 30;
        if (s > 64'd32767)
            s = 64'd32767;
        sine_entry = neg ? TW_W'(64'd0 - s) : TW_W'(s);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int p = 0; p < SINE_TABLE_ENTRIES; p++)
        begin
            rom[p] = sine_entry(p);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/direct_dft_idft_engine_unit.sv
// loading: the block takes words until last_sample, then the divider works out the phase step;
// each bin then runs its products and, in inverse mode, a divide (DIV_W = 25 divider steps)
// throughput: one shared complex multiply-accumulate does one product per cycle, so the
// bins of a block are worked out one after another; the block takes no word meanwhile
// reset: forward mode, 64 points, empty block; the sample store is not cleared
module direct_dft_idft_engine_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ddft_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ddft_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_re,
    input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_im,
    input  logic                                    last_sample,
    output logic                                    bin_valid,
    input  logic                                    bin_stall,
    output logic [ddft_pkg::IDX_W-1:0]              bin_index,
    output logic signed [ddft_pkg::OUT_W-1:0]       out_re,
    output logic signed [ddft_pkg::OUT_W-1:0]       out_im,
    output logic [ddft_pkg::POW_W-1:0]              power,
    output logic                                    last_bin
);

    // phase kept as quotient and remainder of (4*n*k*T + 2*N) / (4*N)
    typedef struct packed {
        logic [ddft_pkg::ROM_AW-1:0] q;
        logic [ddft_pkg::R_W-1:0]    r;
    } phase_t;

    ddft_pkg::state_t state_reg;
    ddft_pkg::state_t state_next;

    logic                                  inverse_reg;
    logic [ddft_pkg::CFG_DATA_W-1:0]       points_reg;
    logic [ddft_pkg::PT_W-1:0]             cnt_reg;
    logic [ddft_pkg::PT_W-1:0]             cnt_next;
    logic [ddft_pkg::IDX_W-1:0]            i_reg;
    logic [ddft_pkg::IDX_W-1:0]            i_next;
    logic [ddft_pkg::IDX_W-1:0]            k_reg;
    logic [ddft_pkg::IDX_W-1:0]            k_next;

    logic [2*ddft_pkg::SAMPLE_BITS-1:0]    store_mem [ddft_pkg::MAX_POINTS];
    logic [2*ddft_pkg::SAMPLE_BITS-1:0]    rd_reg;
    logic signed [ddft_pkg::TW_W-1:0]      sin_reg;
    logic signed [ddft_pkg::TW_W-1:0]      cos_reg;

    logic                                  p1_valid_reg;
    logic                                  p1_zero_reg;
    logic                                  p2_valid_reg;
    logic signed [ddft_pkg::PROD_W-1:0]    pcr_reg;
    logic signed [ddft_pkg::PROD_W-1:0]    psi_reg;
    logic signed [ddft_pkg::PROD_W-1:0]    pci_reg;
    logic signed [ddft_pkg::PROD_W-1:0]    psr_reg;
    logic signed [ddft_pkg::ACC_W-1:0]     acc_re_reg;
    logic signed [ddft_pkg::ACC_W-1:0]     acc_im_reg;

    phase_t                                phase_reg;
    phase_t                                step_reg;
    phase_t                                base_reg;

    logic signed [ddft_pkg::DIV_W-1:0]     w_re_reg;
    logic signed [ddft_pkg::DIV_W-1:0]     w_im_reg;
    logic signed [ddft_pkg::OUT_W-1:0]     res_re_reg;
    logic signed [ddft_pkg::OUT_W-1:0]     res_im_reg;
    logic [ddft_pkg::POW_W-1:0]            sq_re_reg;
    logic [ddft_pkg::POW_W-1:0]            sq_im_reg;

    logic                                  bin_valid_reg;
    logic [ddft_pkg::IDX_W-1:0]            bin_index_reg;
    logic signed [ddft_pkg::OUT_W-1:0]     out_re_reg;
    logic signed [ddft_pkg::OUT_W-1:0]     out_im_reg;
    logic [ddft_pkg::POW_W-1:0]            power_reg;
    logic                                  last_bin_reg;

    logic [ddft_pkg::PT_W-1:0]             n_eff;
    logic [ddft_pkg::R_W:0]                four_n;
    logic                                  sample_fire;
    logic                                  store_wr;
    logic                                  out_free;
    logic                                  emit_fire;
    logic                                  is_last_bin;

    logic                                  div_start;
    logic                                  div_done;
    logic [ddft_pkg::DIV_W-1:0]            div_a;
    logic [ddft_pkg::DIV_W-1:0]            div_b;
    logic [ddft_pkg::DIV_W-1:0]            quot_a;
    logic [ddft_pkg::DIV_W-1:0]            quot_b;
    logic [ddft_pkg::PT_W-1:0]             rem_a;

    logic signed [ddft_pkg::SAMPLE_BITS-1:0] x_re;
    logic signed [ddft_pkg::SAMPLE_BITS-1:0] x_im;
    logic signed [ddft_pkg::V_W-1:0]       v_re;
    logic signed [ddft_pkg::V_W-1:0]       v_im;
    logic [ddft_pkg::V_W-1:0]              rnd;
    logic signed [ddft_pkg::DIV_W:0]       src_re;
    logic signed [ddft_pkg::DIV_W:0]       src_im;
    logic signed [2*ddft_pkg::OUT_W-1:0]   sq_re_full;
    logic signed [2*ddft_pkg::OUT_W-1:0]   sq_im_full;
    logic [ddft_pkg::POW_W:0]              pow_sum;

    function automatic phase_t phase_add(input phase_t a, input phase_t b,
                                         input logic [ddft_pkg::R_W:0] lim);
        logic [ddft_pkg::R_W:0] rsum;
        phase_t                 res;
        rsum = {1'b0, a.r} + {1'b0, b.r};
        if (rsum >= lim)
        begin
            res.r = ddft_pkg::R_W'(rsum - lim);
            res.q = a.q + b.q + 1'b1;
        end
        else
        begin
            res.r = rsum[ddft_pkg::R_W-1:0];
            res.q = a.q + b.q;
        end
        return res;
    endfunction

    function automatic logic signed [ddft_pkg::OUT_W-1:0] sat_out(
        input logic signed [ddft_pkg::DIV_W:0] v);
        logic [ddft_pkg::DIV_W-ddft_pkg::OUT_W+1:0] top;
        top = v[ddft_pkg::DIV_W:ddft_pkg::OUT_W-1];
        if ((top == '0) || (top == '1))
            return v[ddft_pkg::OUT_W-1:0];
        else if (v[ddft_pkg::DIV_W])
            return {1'b1, {(ddft_pkg::OUT_W-1){1'b0}}};
        else
            return {1'b0, {(ddft_pkg::OUT_W-1){1'b1}}};
    endfunction

    // length out of range acts as the nearest legal one
    always_comb
    begin
        if (points_reg == '0)
            n_eff = ddft_pkg::PT_W'(1);
        else if (points_reg > ddft_pkg::CFG_DATA_W'(ddft_pkg::MAX_POINTS))
            n_eff = ddft_pkg::PT_W'(ddft_pkg::MAX_POINTS);
        else
            n_eff = ddft_pkg::PT_W'(points_reg);
    end

    assign four_n      = (ddft_pkg::R_W+1)'({n_eff, 2'b00});
    assign cfg_ready   = 1'b1;
    assign sample_stall = (state_reg != ddft_pkg::ST_LOAD);
    assign sample_fire = sample_valid && !sample_stall;
    assign store_wr    = sample_fire && (cnt_reg < n_eff);
    assign out_free    = !bin_valid_reg || !bin_stall;
    assign emit_fire   = (state_reg == ddft_pkg::ST_EMIT) && out_free;
    assign is_last_bin = (ddft_pkg::PT_W'(k_reg) == (n_eff - ddft_pkg::PT_W'(1)));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
            points_reg  <= ddft_pkg::POINTS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ddft_pkg::REG_INVERSE_MODE:  inverse_reg <= cfg_data[0];
                ddft_pkg::REG_POINTS_IN_USE: points_reg  <= cfg_data;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddft_pkg::ST_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ddft_pkg::ST_LOAD:
            begin
                if (store_wr)
                    cnt_next = cnt_reg + 1'b1;
                if (sample_fire && last_sample)
                    state_next = ddft_pkg::ST_STEP_GO;
            end
            ddft_pkg::ST_STEP_GO:
            begin
                div_start  = 1'b1;
                state_next = ddft_pkg::ST_STEP_WAIT;
            end
            ddft_pkg::ST_STEP_WAIT:
            begin
                if (div_done)
                begin
                    k_next     = '0;
                    state_next = ddft_pkg::ST_BIN_START;
                end
            end
            ddft_pkg::ST_BIN_START:
            begin
                i_next     = '0;
                state_next = ddft_pkg::ST_MAC;
            end
            ddft_pkg::ST_MAC:
            begin
                if (ddft_pkg::PT_W'(i_reg) == (n_eff - ddft_pkg::PT_W'(1)))
                    state_next = ddft_pkg::ST_DRAIN;
                else
                    i_next = i_reg + 1'b1;
            end
            ddft_pkg::ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                    state_next = ddft_pkg::ST_SCALE;
            end
            ddft_pkg::ST_SCALE:
            begin
                state_next = inverse_reg ? ddft_pkg::ST_DIV_GO : ddft_pkg::ST_SAT;
            end
            ddft_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ddft_pkg::ST_DIV_WAIT;
            end
            ddft_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ddft_pkg::ST_SAT;
            end
            ddft_pkg::ST_SAT:
            begin
                state_next = ddft_pkg::ST_SQUARE;
            end
            ddft_pkg::ST_SQUARE:
            begin
                state_next = ddft_pkg::ST_EMIT;
            end
            ddft_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if (is_last_bin)
                    begin
                        cnt_next   = '0;
                        state_next = ddft_pkg::ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ddft_pkg::ST_BIN_START;
                    end
                end
            end
            default:
            begin
                state_next = ddft_pkg::ST_LOAD;
            end
        endcase
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (store_wr)
            store_mem[cnt_reg[ddft_pkg::IDX_W-1:0]] <= {sample_im, sample_re};
        if (state_reg == ddft_pkg::ST_MAC)
            rd_reg <= store_mem[i_reg];
    end

    // twiddle rom, sin and cos read a quarter turn apart
    always_ff @(posedge clk)
    begin
        if (state_reg == ddft_pkg::ST_MAC)
        begin
            sin_reg <= ddft_pkg::SINE_ROM[phase_reg.q];
            cos_reg <= ddft_pkg::SINE_ROM[phase_reg.q +
                       ddft_pkg::ROM_AW'(ddft_pkg::SINE_TABLE_ENTRIES / 4)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= (state_reg == ddft_pkg::ST_MAC);
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // positions past the loaded count read as zero
    assign x_re = p1_zero_reg ? '0 : rd_reg[ddft_pkg::SAMPLE_BITS-1:0];
    assign x_im = p1_zero_reg ? '0 : rd_reg[2*ddft_pkg::SAMPLE_BITS-1:ddft_pkg::SAMPLE_BITS];

    assign rnd  = inverse_reg ? (ddft_pkg::V_W'(n_eff) << (ddft_pkg::FRAC - 1))
                              : (ddft_pkg::V_W'(1) << (ddft_pkg::FRAC - 1));
    assign v_re = ddft_pkg::V_W'(acc_re_reg) + $signed(rnd);
    assign v_im = ddft_pkg::V_W'(acc_im_reg) + $signed(rnd);

    // floor division of a negative value: -((-w + n - 1) / n), and -w + n - 1 = ~w + n
    assign div_a = (state_reg == ddft_pkg::ST_STEP_GO)
                 ? ddft_pkg::DIV_W'(ddft_pkg::SINE_TABLE_ENTRIES)
                 : (w_re_reg[ddft_pkg::DIV_W-1] ? (~w_re_reg + ddft_pkg::DIV_W'(n_eff))
                                                : w_re_reg);
    assign div_b = w_im_reg[ddft_pkg::DIV_W-1] ? (~w_im_reg + ddft_pkg::DIV_W'(n_eff))
                                               : w_im_reg;

    always_comb
    begin
        if (inverse_reg)
        begin
            src_re = w_re_reg[ddft_pkg::DIV_W-1] ? -$signed({1'b0, quot_a})
                                                 : $signed({1'b0, quot_a});
            src_im = w_im_reg[ddft_pkg::DIV_W-1] ? -$signed({1'b0, quot_b})
                                                 : $signed({1'b0, quot_b});
        end
        else
        begin
            src_re = {w_re_reg[ddft_pkg::DIV_W-1], w_re_reg};
            src_im = {w_im_reg[ddft_pkg::DIV_W-1], w_im_reg};
        end
    end

    assign sq_re_full = res_re_reg * res_re_reg;
    assign sq_im_full = res_im_reg * res_im_reg;
    assign pow_sum    = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};

    always_ff @(posedge clk)
    begin
        if ((state_reg == ddft_pkg::ST_STEP_WAIT) && div_done)
        begin
            base_reg.q <= quot_a[ddft_pkg::ROM_AW-1:0];
            base_reg.r <= ddft_pkg::R_W'({rem_a, 2'b00});
            step_reg   <= '0;
        end
        else if (emit_fire)
        begin
            step_reg <= phase_add(step_reg, base_reg, four_n);
        end

        if (state_reg == ddft_pkg::ST_BIN_START)
        begin
            phase_reg.q <= '0;
            phase_reg.r <= ddft_pkg::R_W'({n_eff, 1'b0});
        end
        else if (state_reg == ddft_pkg::ST_MAC)
        begin
            phase_reg   <= phase_add(phase_reg, step_reg, four_n);
            p1_zero_reg <= !(ddft_pkg::PT_W'(i_reg) < cnt_reg);
        end

        if (p1_valid_reg)
        begin
            pcr_reg <= x_re * cos_reg;
            psi_reg <= x_im * sin_reg;
            pci_reg <= x_im * cos_reg;
            psr_reg <= x_re * sin_reg;
        end

        if (state_reg == ddft_pkg::ST_BIN_START)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (p2_valid_reg)
        begin
            if (inverse_reg)
            begin
                acc_re_reg <= acc_re_reg + ddft_pkg::ACC_W'(pcr_reg) - ddft_pkg::ACC_W'(psi_reg);
                acc_im_reg <= acc_im_reg + ddft_pkg::ACC_W'(pci_reg) + ddft_pkg::ACC_W'(psr_reg);
            end
            else
            begin
                acc_re_reg <= acc_re_reg + ddft_pkg::ACC_W'(pcr_reg) + ddft_pkg::ACC_W'(psi_reg);
                acc_im_reg <= acc_im_reg + ddft_pkg::ACC_W'(pci_reg) - ddft_pkg::ACC_W'(psr_reg);
            end
        end

        if (state_reg == ddft_pkg::ST_SCALE)
        begin
            w_re_reg <= v_re[ddft_pkg::V_W-1:ddft_pkg::FRAC];
            w_im_reg <= v_im[ddft_pkg::V_W-1:ddft_pkg::FRAC];
        end

        if (state_reg == ddft_pkg::ST_SAT)
        begin
            res_re_reg <= sat_out(src_re);
            res_im_reg <= sat_out(src_im);
        end

        if (state_reg == ddft_pkg::ST_SQUARE)
        begin
            sq_re_reg <= sq_re_full[ddft_pkg::POW_W-1:0];
            sq_im_reg <= sq_im_full[ddft_pkg::POW_W-1:0];
        end

        if (emit_fire)
        begin
            bin_index_reg <= k_reg;
            out_re_reg    <= res_re_reg;
            out_im_reg    <= res_im_reg;
            power_reg     <= pow_sum[ddft_pkg::POW_W] ? '1 : pow_sum[ddft_pkg::POW_W-1:0];
            last_bin_reg  <= is_last_bin;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bin_valid_reg <= 1'b0;
        else if (emit_fire)
            bin_valid_reg <= 1'b1;
        else if (!bin_stall)
            bin_valid_reg <= 1'b0;
    end

    ddft_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .divisor    (n_eff),
        .dividend_a (div_a),
        .dividend_b (div_b),
        .done       (div_done),
        .quot_a     (quot_a),
        .quot_b     (quot_b),
        .rem_a      (rem_a)
    );

    assign bin_valid = bin_valid_reg;
    assign bin_index = bin_index_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign power     = power_reg;
    assign last_bin  = last_bin_reg;

endmodule

FILE: rtl/ddft_div.sv
// two-lane restoring divider, one quotient bit per cycle, shared divisor
// depends on ddft_pkg for widths
module ddft_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ddft_pkg::PT_W-1:0]    divisor,
    input  logic [ddft_pkg::DIV_W-1:0]   dividend_a,
    input  logic [ddft_pkg::DIV_W-1:0]   dividend_b,
    output logic                         done,
    output logic [ddft_pkg::DIV_W-1:0]   quot_a,
    output logic [ddft_pkg::DIV_W-1:0]   quot_b,
    output logic [ddft_pkg::PT_W-1:0]    rem_a
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [ddft_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [ddft_pkg::PT_W-1:0]         div_reg;
    logic [ddft_pkg::DIV_W-1:0]        qa_reg;
    logic [ddft_pkg::DIV_W-1:0]        qb_reg;
    logic [ddft_pkg::PT_W-1:0]         ra_reg;
    logic [ddft_pkg::PT_W-1:0]         rb_reg;

    logic [ddft_pkg::PT_W:0]           shift_a;
    logic [ddft_pkg::PT_W:0]           shift_b;
    logic [ddft_pkg::PT_W:0]           div_ext;
    logic                              ge_a;
    logic                              ge_b;

    assign div_ext = {1'b0, div_reg};
    assign shift_a = {ra_reg, qa_reg[ddft_pkg::DIV_W-1]};
    assign shift_b = {rb_reg, qb_reg[ddft_pkg::DIV_W-1]};
    assign ge_a    = shift_a >= div_ext;
    assign ge_b    = shift_b >= div_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ddft_pkg::DIV_CNT_W'(ddft_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend shifts out of the top while quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            qa_reg  <= dividend_a;
            qb_reg  <= dividend_b;
            ra_reg  <= '0;
            rb_reg  <= '0;
        end
        else if (busy_reg)
        begin
            qa_reg <= {qa_reg[ddft_pkg::DIV_W-2:0], ge_a};
            qb_reg <= {qb_reg[ddft_pkg::DIV_W-2:0], ge_b};
            ra_reg <= ge_a ? ddft_pkg::PT_W'(shift_a - div_ext) : ddft_pkg::PT_W'(shift_a);
            rb_reg <= ge_b ? ddft_pkg::PT_W'(shift_b - div_ext) : ddft_pkg::PT_W'(shift_b);
        end
    end

    assign done   = done_reg;
    assign quot_a = qa_reg;
    assign quot_b = qb_reg;
    assign rem_a  = ra_reg;

endmodule

FILE: test/direct_dft_idft_engine_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for direct_dft_idft_engine_unit: a spectrum scoreboard recomputes
// every bin from its own q1.15 twiddle table and checks the engine's bin words in order
// depends on ddft_pkg and the engine rtl
module direct_dft_idft_engine_unit_tb;
    import ddft_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 600;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_WORDS   = 200;
    localparam int REPORT_CAP     = 50;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
    localparam longint OUT_HIGH   = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LOW    = -(64'sd1 <<< (OUT_W - 1));
    localparam longint POWER_CEIL = (64'sd1 <<< POW_W) - 1;

    typedef enum int { STYLE_RANDOM, STYLE_EXTREME, STYLE_SMALL, STYLE_SWEEP } word_style_e;
    typedef enum int { FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY } stall_mode_e;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic [POW_W-1:0]        pwr;
        logic                    last;
    } bin_word_t;

    class spectrum_scoreboard;
        logic                  inverse;
        logic [CFG_DATA_W-1:0] points;
        longint                held_re [MAX_POINTS];
        longint                held_im [MAX_POINTS];
        int                    loaded;
        longint                sine_q15 [SINE_TABLE_ENTRIES];
        bin_word_t             expected_bins [$];
        int                    errors;

        function new();
            for (int p = 0; p < SINE_TABLE_ENTRIES; p++)
            begin
                sine_q15[p] = sine_at(p);
            end
            inverse = 1'b0;
            points  = POINTS_RESET;
            loaded  = 0;
            errors  = 0;
        endfunction

        // quarter-wave fold, then taylor series in q2.30 truncated at every step
        function longint sine_at(int p);
            longint unsigned turn;
            longint unsigned ang;
            longint unsigned sq;
            longint unsigned poly;
            longint unsigned mag;
            longint unsigned taylor_div [5];
            logic            negative;
            taylor_div = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            turn = (longint'(p) << 32) / SINE_TABLE_ENTRIES;
            negative = (turn >= 64'h8000_0000);
            if (negative)
                turn = turn - 64'h8000_0000;
            if (turn > 64'h4000_0000)
                turn = 64'h8000_0000 - turn;
            ang = (turn * TWO_PI_Q29 + 64'h4000_0000) >> 31;
            sq = (ang * ang) >> 30;
            poly = ONE_Q30;
            foreach (taylor_div[i])
            begin
                poly = ONE_Q30 - (((sq * poly) >> 30) / taylor_div[i]);
            end
            mag = (ang * poly) >> 30;
            mag = (mag * 64'd32767 + 64'h2000_0000) >> 30;
            if (mag > 64'd32767)
                mag = 64'd32767;
            return negative ? -longint'(mag) : longint'(mag);
        endfunction

        function longint twiddle(longint unsigned num, int n);
            longint unsigned addr;
            addr = ((num * SINE_TABLE_ENTRIES + 2 * n) / (4 * n)) % SINE_TABLE_ENTRIES;
            return sine_q15[addr];
        endfunction

        function int span();
            if (points == 0)
                return 1;
            if (points > MAX_POINTS)
                return MAX_POINTS;
            return int'(points);
        endfunction

        function longint floor_div(longint v, longint d);
            if (v >= 0)
                return v / d;
            return -((-v + d - 1) / d);
        endfunction

        function longint clamp_out(longint v);
            if (v > OUT_HIGH)
                return OUT_HIGH;
            if (v < OUT_LOW)
                return OUT_LOW;
            return v;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_INVERSE_MODE)
                inverse = data[0];
            else
                points = data;
        endfunction

        function void load_sample(logic signed [SAMPLE_BITS-1:0] re,
                                  logic signed [SAMPLE_BITS-1:0] im, logic last);
            int n;
            n = span();
            // words past the block length are dropped
            if (loaded < n)
            begin
                held_re[loaded] = re;
                held_im[loaded] = im;
                loaded++;
            end
            if (last)
                spectrum_of_block(n);
        endfunction

        function void spectrum_of_block(int n);
            for (int k = 0; k < n; k++)
            begin
                longint    acc_re;
                longint    acc_im;
                longint    s;
                longint    c;
                longint    xr;
                longint    xi;
                longint    re;
                longint    im;
                longint    pw;
                bin_word_t w;
                acc_re = 0;
                acc_im = 0;
                for (int i = 0; i < n; i++)
                begin
                    longint unsigned ph;
                    ph = (i * k) % n;
                    s = twiddle(4 * ph, n);
                    c = twiddle(4 * ph + n, n);
                    // a short block reads as zero past its last word
                    xr = (i < loaded) ? held_re[i] : 0;
                    xi = (i < loaded) ? held_im[i] : 0;
                    if (inverse)
                    begin
                        acc_re += xr * c - xi * s;
                        acc_im += xr * s + xi * c;
                    end
                    else
                    begin
                        acc_re += xr * c + xi * s;
                        acc_im += xi * c - xr * s;
                    end
                end
                if (inverse)
                begin
                    re = floor_div(acc_re + (longint'(n) << 14), longint'(n) << 15);
                    im = floor_div(acc_im + (longint'(n) << 14), longint'(n) << 15);
                end
                else
                begin
                    re = floor_div(acc_re + (64'sd1 << 14), 64'sd1 << 15);
                    im = floor_div(acc_im + (64'sd1 << 14), 64'sd1 << 15);
                end
                re = clamp_out(re);
                im = clamp_out(im);
                pw = re * re + im * im;
                if (pw > POWER_CEIL)
                    pw = POWER_CEIL;
                w.idx  = IDX_W'(k);
                w.re   = OUT_W'(re);
                w.im   = OUT_W'(im);
                w.pwr  = POW_W'(pw);
                w.last = (k == n - 1);
                expected_bins.push_back(w);
            end
            loaded = 0;
        endfunction

        task report(string msg);
            if (errors < REPORT_CAP)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_bin(bin_word_t got);
            bin_word_t want;
            if (expected_bins.size() == 0)
            begin
                report($sformatf("bin word %0d arrived with nothing expected", got.idx));
                return;
            end
            want = expected_bins.pop_front();
            if (got.idx !== want.idx)
                report($sformatf("bin_index got %0d want %0d", got.idx, want.idx));
            if (got.re !== want.re)
                report($sformatf("bin %0d out_re got %0d want %0d", want.idx, got.re, want.re));
            if (got.im !== want.im)
                report($sformatf("bin %0d out_im got %0d want %0d", want.idx, got.im, want.im));
            if (got.pwr !== want.pwr)
                report($sformatf("bin %0d power got %0d want %0d", want.idx, got.pwr, want.pwr));
            if (got.last !== want.last)
                report($sformatf("bin %0d last_bin got %b want %b", want.idx, got.last,
                                 want.last));
        endtask
    endclass

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index    = REG_INVERSE_MODE;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic signed [SAMPLE_BITS-1:0] sample_re    = '0;
    logic signed [SAMPLE_BITS-1:0] sample_im    = '0;
    logic                          last_sample  = 1'b0;
    logic                          bin_valid;
    logic                          bin_stall    = 1'b0;
    logic [IDX_W-1:0]              bin_index;
    logic signed [OUT_W-1:0]       out_re;
    logic signed [OUT_W-1:0]       out_im;
    logic [POW_W-1:0]              power;
    logic                          last_bin;

    spectrum_scoreboard sb;
    bin_word_t          seen;
    bit                 offering     = 1'b0;
    int                 burst_left   = 5;
    int                 words_sent   = 0;
    int                 holds_asked  = 0;
    int                 holds_granted = 0;
    int                 hold_left    = 0;
    int                 pattern_left = 0;
    stall_mode_e        pattern_mode = FLOW_FREE;
    int                 quiet_cycles = 0;

    direct_dft_idft_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .last_sample  (last_sample),
        .bin_valid    (bin_valid),
        .bin_stall    (bin_stall),
        .bin_index    (bin_index),
        .out_re       (out_re),
        .out_im       (out_im),
        .power        (power),
        .last_bin     (last_bin)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: free, light and heavy stall stretches, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (holds_granted != holds_asked)
        begin
            holds_granted = holds_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            bin_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_mode = stall_mode_e'($urandom_range(0, 2));
                pattern_left = $urandom_range(4, 80);
            end
            pattern_left--;
            case (pattern_mode)
                FLOW_FREE:  bin_stall <= 1'b0;
                FLOW_LIGHT: bin_stall <= ($urandom_range(0, 3) == 0);
                default:    bin_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && bin_valid === 1'b1 && bin_stall === 1'b0)
        begin
            seen.idx  = bin_index;
            seen.re   = out_re;
            seen.im   = out_im;
            seen.pwr  = power;
            seen.last = last_bin;
            sb.compare_bin(seen);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (bin_valid && !bin_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // valid stays up across a burst; a gap drops it for a random number of cycles
    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] re,
                             input logic signed [SAMPLE_BITS-1:0] im, input logic last);
        sample_re    <= re;
        sample_im    <= im;
        last_sample  <= last;
        sample_valid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (sample_stall !== 1'b0)
            @(posedge clk);
        sb.load_sample(re, im, last);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            sample_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_extreme();
        case ($urandom_range(0, 2))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            default: return '0;
        endcase
    endfunction

    // len words, last_sample on the final one
    task automatic send_block(input word_style_e style, input int len);
        int n;
        n = sb.span();
        for (int i = 0; i < len; i++)
        begin
            logic signed [SAMPLE_BITS-1:0] re;
            logic signed [SAMPLE_BITS-1:0] im;
            case (style)
                STYLE_EXTREME:
                begin
                    re = pick_extreme();
                    im = pick_extreme();
                end
                STYLE_SMALL:
                begin
                    re = SAMPLE_BITS'(int'($urandom_range(0, 127)) - 64);
                    im = SAMPLE_BITS'(int'($urandom_range(0, 127)) - 64);
                end
                // signs follow bin 1 of a 64 point turn, so that bin overflows
                STYLE_SWEEP:
                begin
                    re = (i <= 16 || i >= 48) ? SAMPLE_MAX : SAMPLE_MIN;
                    im = (i <= 32) ? SAMPLE_MAX : SAMPLE_MIN;
                end
                default:
                begin
                    re = SAMPLE_BITS'($urandom);
                    im = SAMPLE_BITS'($urandom);
                end
            endcase
            if (i < n || i == len - 1)
                words_sent++;
            send_word(re, im, i == len - 1);
        end
    endtask

    task automatic settle();
        if (offering)
        begin
            sample_valid <= 1'b0;
            offering = 1'b0;
        end
        while (sb.expected_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers back to back, valid held high between the two writes
    task automatic set_config(input logic inv, input logic [CFG_DATA_W-1:0] pts);
        settle();
        cfg_index <= REG_INVERSE_MODE;
        cfg_data  <= CFG_DATA_W'(inv);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.write_register(REG_INVERSE_MODE, CFG_DATA_W'(inv));
        cfg_index <= REG_POINTS_IN_USE;
        cfg_data  <= pts;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.write_register(REG_POINTS_IN_USE, pts);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] pts;
        int                    pick;
        int                    blocks;
        int                    n;
        int                    len;
        int                    shape;
        word_style_e           style;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting, short block of extremes
        send_word(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_word(16'sd1, -16'sd1, 1'b1);
        // single point, inverse
        set_config(1'b1, 7'd1);
        send_word(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        // zero length acts as one point
        set_config(1'b0, 7'd0);
        send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        // length above the maximum acts as the maximum
        set_config(1'b1, 7'd127);
        send_word(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        // overlong block: the last two words are dropped
        set_config(1'b0, 7'd4);
        send_word(16'sd100, -16'sd100, 1'b0);
        send_word(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_word(-16'sd1, 16'sd0, 1'b0);
        send_word(16'sd5, 16'sd5, 1'b0);
        send_word(16'sd7, 16'sd7, 1'b1);
        set_config(1'b1, 7'd3);
        send_word(SAMPLE_MAX, 16'sd0, 1'b0);
        send_word(16'sd0, SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        send_word(SAMPLE_MIN, SAMPLE_MAX, 1'b1);

        // overflowing block while the receiver holds off; the next block waits at the input
        set_config(1'b0, 7'd64);
        holds_asked <= holds_asked + 1;
        send_block(STYLE_SWEEP, 64);
        send_block(STYLE_RANDOM, 8);

        while (words_sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                pts = $urandom_range(1, 16);
            else if (pick < 16)
                pts = $urandom_range(17, 63);
            else if (pick == 16)
                pts = 7'd64;
            else if (pick == 17)
                pts = $urandom_range(65, 127);
            else
                pts = $urandom_range(0, 1);
            set_config($urandom_range(0, 1), pts);
            n = sb.span();
            blocks = (n > 16) ? 1 : $urandom_range(1, 4);
            for (int b = 0; b < blocks; b++)
            begin
                shape = $urandom_range(0, 9);
                if (shape < 7 || n == 1 && shape == 7)
                    len = n;
                else if (shape == 7)
                    len = $urandom_range(1, n - 1);
                else
                    len = n + $urandom_range(1, 3);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    style = STYLE_RANDOM;
                else if (pick < 8)
                    style = STYLE_EXTREME;
                else
                    style = STYLE_SMALL;
                send_block(style, len);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
